// File: hw/rtl/utf8v_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
package utf8v_pkg;

    localparam int unsigned BYTE_W = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        MIN_NONE = 2'd0,
        MIN_A0   = 2'd1,
        MIN_90   = 2'd2,
        MIN_RSVD = 2'd3
    } min_kind_t;

    typedef struct packed {
        logic [1:0] owed;
        min_kind_t  min_kind;
        logic       failed;
    } val_state_t;

    localparam val_state_t STATE_RESET = '{owed: 2'd0, min_kind: MIN_NONE, failed: 1'b0};

    localparam byte_t ASCII_END   = 8'h80;
    localparam byte_t LEAD2_MIN   = 8'hC2;
    localparam byte_t LEAD3_MIN   = 8'hE0;
    localparam byte_t LEAD4_MIN   = 8'hF0;
    localparam byte_t LEAD_BAD    = 8'hF8;
    localparam byte_t CONT_MIN    = 8'h80;
    localparam byte_t CONT_MIN_E0 = 8'hA0;
    localparam byte_t CONT_MIN_F0 = 8'h90;

endpackage

// File: hw/rtl/utf8_stream_validator_top.sv
// UTF-8 stream validator: top level with input and result registers.
//
// Usage: send a string one byte per beat on the input channel (in_valid,
// in_ready, byte_in, is_last), with is_last high on the final byte. Each
// string yields exactly one beat on the output channel (out_valid,
// out_ready, valid_res): 1 if the whole string is UTF-8, surrogates and
// code points to 1FFFFF allowed. Bytes without is_last produce nothing.
// The final byte is held in the input register and its verdict in the
// result register, which drives the output channel.
// Throughput: one byte per cycle but for a stalled final byte; the decode
// is a few compares on a two-bit pending count between the registers.
// Reset clears the pending-count, raised-minimum and error state, so the
// first byte after reset starts a new string; no results are held.
// When the receiver stalls, the verdict holds in the result register and
// non-final bytes keep flowing; a final byte waits in the input register,
// with in_ready low, until the result register frees.
// After each verdict the state returns to its reset value.
module utf8_stream_validator_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  utf8v_pkg::byte_t byte_in,
    input  logic             is_last,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             valid_res
);
    import utf8v_pkg::*;

    logic       in_valid_reg;
    byte_t      byte_reg;
    logic       last_reg;
    val_state_t state_reg;
    val_state_t state_next;
    logic       out_valid_reg;
    logic       res_reg;
    logic       verdict;
    logic       advance;
    logic       out_take;

    assign out_take = out_valid_reg && out_ready;
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    utf8v_step u_step (
        .byte_in    (byte_reg),
        .is_last    (last_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .verdict    (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= byte_in;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            res_reg <= verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = res_reg;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> state_reg == STATE_RESET)
        else $error("state not cleared after final beat");

    a_min_needs_owed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.min_kind != MIN_NONE |-> state_reg.owed >= 2'd2)
        else $error("raised minimum pending without owed bytes");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready && last_reg)
        else $error("input stalled without a blocked verdict");
`endif

endmodule

// File: hw/rtl/utf8v_step.sv
// Per-byte decode: classifies one byte against the pending state.
module utf8v_step (
    input  utf8v_pkg::byte_t      byte_in,
    input  logic                  is_last,
    input  utf8v_pkg::val_state_t state_cur,
    output utf8v_pkg::val_state_t state_next,
    output logic                  verdict
);
    import utf8v_pkg::*;

    byte_t      cont_min;
    val_state_t upd;

    always_comb
    begin
        case (state_cur.min_kind)
            MIN_A0:  cont_min = CONT_MIN_E0;
            MIN_90:  cont_min = CONT_MIN_F0;
            default: cont_min = CONT_MIN;
        endcase
    end

    always_comb
    begin
        upd = state_cur;
        if (state_cur.owed != 2'd0)
        begin
            if ((byte_in[7:6] != 2'b10) || (byte_in < cont_min))
            begin
                upd.failed = 1'b1;
            end
            upd.min_kind = MIN_NONE;
            upd.owed     = state_cur.owed - 2'd1;
        end
        else if (byte_in >= ASCII_END)
        begin
            if (byte_in < LEAD2_MIN)
            begin
                upd.failed = 1'b1;
            end
            else if (byte_in < LEAD3_MIN)
            begin
                upd.owed = 2'd1;
            end
            else if (byte_in < LEAD4_MIN)
            begin
                upd.owed     = 2'd2;
                upd.min_kind = (byte_in == LEAD3_MIN) ? MIN_A0 : MIN_NONE;
            end
            else if (byte_in < LEAD_BAD)
            begin
                upd.owed     = 2'd3;
                upd.min_kind = (byte_in == LEAD4_MIN) ? MIN_90 : MIN_NONE;
            end
            else
            begin
                upd.failed = 1'b1;
            end
        end
    end

    assign verdict    = !upd.failed && (upd.owed == 2'd0);
    assign state_next = is_last ? STATE_RESET : upd;

endmodule

// File: dv/utf8_stream_validator_top_tb.sv
// Self-checking testbench for utf8_stream_validator_top: directed strings, then random strings.
module utf8_stream_validator_top_tb;

    import utf8v_pkg::*;

    typedef enum logic [1:0] {
        FROM_MODEL = 2'd0,
        KNOWN_GOOD = 2'd1,
        KNOWN_BAD  = 2'd2
    } want_t;

    typedef struct {
        byte_t b;
        logic  last;
        want_t want;
    } dir_beat_t;

    localparam int NUM_DIRECTED = 26;
    localparam int NUM_RANDOM   = 950;

    logic  clk;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    byte_t byte_in   = '0;
    logic  is_last   = 1'b0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    logic  valid_res;

    // utf-8 decode state tracked alongside the block
    logic [1:0] owed;
    min_kind_t  min_kind;
    logic       broken;

    logic expected_verdicts[$];
    int   mismatches;
    int   beats_sent;
    int   burst_left;

    dir_beat_t directed [NUM_DIRECTED] = '{
        '{8'h00, 1'b1, KNOWN_GOOD},
        '{8'h7F, 1'b1, KNOWN_GOOD},
        '{8'hFF, 1'b1, KNOWN_BAD},
        '{8'hF8, 1'b1, KNOWN_BAD},
        '{8'h80, 1'b0, FROM_MODEL},   // stray continuation, then sticky error
        '{8'h41, 1'b1, KNOWN_BAD},
        '{8'hC1, 1'b0, FROM_MODEL},   // overlong lead
        '{8'hBF, 1'b1, KNOWN_BAD},
        '{8'hC2, 1'b0, FROM_MODEL},
        '{8'h80, 1'b1, FROM_MODEL},
        '{8'hE0, 1'b0, FROM_MODEL},   // below raised minimum
        '{8'h9F, 1'b0, FROM_MODEL},
        '{8'hBF, 1'b1, KNOWN_BAD},
        '{8'hED, 1'b0, FROM_MODEL},   // surrogate, accepted
        '{8'hA0, 1'b0, FROM_MODEL},
        '{8'hBF, 1'b1, FROM_MODEL},
        '{8'hF0, 1'b0, FROM_MODEL},
        '{8'h90, 1'b0, FROM_MODEL},
        '{8'h80, 1'b0, FROM_MODEL},
        '{8'hBF, 1'b1, FROM_MODEL},
        '{8'hF7, 1'b0, FROM_MODEL},   // lead above F4, accepted
        '{8'h8F, 1'b0, FROM_MODEL},
        '{8'h80, 1'b0, FROM_MODEL},
        '{8'h80, 1'b1, FROM_MODEL},
        '{8'hE2, 1'b0, FROM_MODEL},   // truncated at end of string
        '{8'h82, 1'b1, KNOWN_BAD}
    };

    byte_t boundary_bytes [17] = '{
        8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0, 8'hBF, 8'hC0, 8'hC1,
        8'hC2, 8'hDF, 8'hE0, 8'hEF, 8'hF0, 8'hF7, 8'hF8, 8'hFF
    };

    utf8_stream_validator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .byte_in   (byte_in),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("utf8_stream_validator_top_tb NOT OK");
        $finish;
    end

    // Advances the decode state by one byte; returns the string verdict
    // (meaningful only when last is set).
    function automatic logic judge_byte(input byte_t b, input logic last);
        byte_t floor_b;
        logic  verdict;
        if (owed != 2'd0)
        begin
            case (min_kind)
                MIN_A0:  floor_b = CONT_MIN_E0;
                MIN_90:  floor_b = CONT_MIN_F0;
                default: floor_b = CONT_MIN;
            endcase
            if (b[7:6] != 2'b10 || b < floor_b)
                broken = 1'b1;
            min_kind = MIN_NONE;
            owed = owed - 2'd1;
        end
        else if (b >= ASCII_END)
        begin
            if (b < LEAD2_MIN)
                broken = 1'b1;
            else if (b < LEAD3_MIN)
                owed = 2'd1;
            else if (b < LEAD4_MIN)
            begin
                owed = 2'd2;
                min_kind = (b == LEAD3_MIN) ? MIN_A0 : MIN_NONE;
            end
            else if (b < LEAD_BAD)
            begin
                owed = 2'd3;
                min_kind = (b == LEAD4_MIN) ? MIN_90 : MIN_NONE;
            end
            else
                broken = 1'b1;
        end
        verdict = !broken && owed == 2'd0;
        if (last)
        begin
            owed = 2'd0;
            min_kind = MIN_NONE;
            broken = 1'b0;
        end
        return verdict;
    endfunction

    task automatic report_mismatch(input string what, input logic want, input logic got);
        if (mismatches < 10)
            $display("%0t: %s: expected valid_res=%0b, got %0b", $realtime, what, want, got);
        mismatches++;
    endtask

    // One input beat; ends a burst with a random gap.
    task automatic send_beat(input byte_t b, input logic last, input want_t want);
        logic verdict;
        int   gap;
        in_valid <= 1'b1;
        byte_in  <= b;
        is_last  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        verdict = judge_byte(b, last);
        if (last)
            expected_verdicts.push_back(want == KNOWN_GOOD ? 1'b1 :
                                        want == KNOWN_BAD  ? 1'b0 : verdict);
        beats_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic drain_verdicts();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic byte_t cont_byte(input byte_t lo);
        return byte_t'($urandom_range(lo, 8'hBF));
    endfunction

    // Mostly well-formed strings; some damaged, truncated or pure noise.
    task automatic send_random_string();
        byte_t bytes[$];
        byte_t lead;
        int    n_chars;
        int    pos;
        int    cut;
        n_chars = $urandom_range(1, 6);
        repeat (n_chars)
        begin
            case ($urandom_range(0, 3))
                0: bytes.push_back(byte_t'($urandom_range(0, 8'h7F)));
                1:
                begin
                    bytes.push_back(byte_t'($urandom_range(LEAD2_MIN, 8'hDF)));
                    bytes.push_back(cont_byte(CONT_MIN));
                end
                2:
                begin
                    lead = ($urandom_range(0, 3) == 0) ? LEAD3_MIN
                                                       : byte_t'($urandom_range(LEAD3_MIN, 8'hEF));
                    bytes.push_back(lead);
                    bytes.push_back(cont_byte(lead == LEAD3_MIN ? CONT_MIN_E0 : CONT_MIN));
                    bytes.push_back(cont_byte(CONT_MIN));
                end
                default:
                begin
                    lead = ($urandom_range(0, 3) == 0) ? LEAD4_MIN
                                                       : byte_t'($urandom_range(LEAD4_MIN, 8'hF7));
                    bytes.push_back(lead);
                    bytes.push_back(cont_byte(lead == LEAD4_MIN ? CONT_MIN_F0 : CONT_MIN));
                    bytes.push_back(cont_byte(CONT_MIN));
                    bytes.push_back(cont_byte(CONT_MIN));
                end
            endcase
        end
        pos = $urandom_range(0, bytes.size() - 1);
        case ($urandom_range(0, 9))
            0: bytes[pos] = byte_t'($urandom_range(0, 255));
            1: bytes[pos] = boundary_bytes[$urandom_range(0, 16)];
            2:
            begin
                if (bytes.size() > 1)
                begin
                    cut = $urandom_range(1, bytes.size() - 1);
                    repeat (cut) void'(bytes.pop_back());
                end
            end
            3:
            begin
                bytes.delete();
                repeat ($urandom_range(1, 5)) bytes.push_back(byte_t'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        foreach (bytes[i])
            send_beat(bytes[i], i == bytes.size() - 1, FROM_MODEL);
    endtask

    // Receiver: stall modes that change after a random span.
    initial
    begin
        int mode;
        int span;
        int phase;
        phase = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span)
            begin
                @(posedge clk);
                phase++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (phase % 5) < 2;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_verdict
        logic want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch("verdict with none pending", 1'bx, valid_res);
            else
            begin
                want = expected_verdicts.pop_front();
                if (valid_res !== want)
                    report_mismatch("verdict mismatch", want, valid_res);
            end
        end
    end

    initial
    begin
        owed       = 2'd0;
        min_kind   = MIN_NONE;
        broken     = 1'b0;
        mismatches = 0;
        beats_sent = 0;
        burst_left = $urandom_range(1, 12);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_beat(directed[i].b, directed[i].last, directed[i].want);
        drain_verdicts();

        beats_sent = 0;
        while (beats_sent < NUM_RANDOM)
        begin
            send_random_string();
            if ($urandom_range(0, 39) == 0)
                drain_verdicts();
        end

        drain_verdicts();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("utf8_stream_validator_top_tb OK");
        else
            $display("utf8_stream_validator_top_tb NOT OK");
        $finish;
    end

endmodule
